>>> hw/rtl/stuffed_frame_encoder_defines.svh
// ---------------------------------------------------------------------------
// Stuffed frame encoder assertion macros
// Shorthand for clocked assertions with the asynchronous reset masked out.
// ---------------------------------------------------------------------------
`ifndef STUFFED_FRAME_ENCODER_DEFINES_SVH
`define STUFFED_FRAME_ENCODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/sfe_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfe_pkg
// Types and constants shared by the stuffed frame encoder modules.
// ---------------------------------------------------------------------------
package sfe_pkg;

	localparam logic OP_HEADER  = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	localparam logic CFG_START_MARKER = 1'b0;
	localparam logic CFG_MIN_FRAME    = 1'b1;

	localparam logic [7:0] STUFF_A    = 8'h88;
	localparam logic [7:0] STUFF_B    = 8'h81;
	localparam logic [7:0] STUFF_FILL = 8'hFF;

	localparam logic [5:0] MIN_FRAME_CAP = 6'd60;
	localparam logic [7:0] HEADER_LEN    = 8'd4;

	localparam logic [7:0] START_MARKER_RST = 8'd126;
	localparam logic [5:0] MIN_FRAME_RST    = 6'd14;

	localparam logic [1:0] LAST_IDX_HEADER  = 2'd3;
	localparam logic [1:0] LAST_IDX_PAYLOAD = 2'd0;

	typedef struct packed {
		logic       operation;
		logic [6:0] length;
		logic [4:0] sequence_req;
		logic [3:0] kind;
		logic [7:0] checksum;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
	} out_item_t;

	// One unit of work for the back end: up to four content bytes, then
	// optional padding and the frame end.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            first_raw;
		logic            close;
		logic [5:0]      pad;
	} job_t;

endpackage

>>> hw/rtl/stuffed_frame_encoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stuffed_frame_encoder
// Byte-stuffing frame encoder: header and payload items in, wire bytes out.
// ---------------------------------------------------------------------------
// Items enter on in_valid/in_ready. A header item produces the start marker,
// two header bytes and the checksum; a payload item produces its data byte.
// Header, checksum and payload bytes of 0x88 or 0x81 are each followed by
// an inserted 0xFF. The frame closes with zero padding up to min_frame,
// capped at 60, and frame_end on its final byte; run_last marks the last
// byte of each item. Wire bytes leave on out_valid/out_ready, one per cycle
// while out_ready is high. An item produces one or two bytes for a payload
// byte, four to seven for a header, plus any padding; the single back-end
// sequencer emits them. From an idle block the first byte of an item passes
// through the job queue, the back-end job register and the output register.
// A job queue of QUEUE_DEPTH entries lets input be taken while the output
// is stalled; when the queue fills, in_ready drops until the receiver moves.
// Reset clears the frame state, the queue and out_valid, sets start_marker
// to 126 and min_frame to 14. Configuration writes via cfg_we take effect
// at once; the user must make them only while the block is idle (unenforced).
// ---------------------------------------------------------------------------
module stuffed_frame_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  sfe_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output sfe_pkg::out_item_t out_item
);
	import sfe_pkg::*;

	logic q_ready;
	logic q_push;
	job_t q_job;
	logic q_valid;
	job_t q_head;
	logic q_pop;

	sfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_ready  (q_ready),
		.q_push   (q_push),
		.q_job    (q_job)
	);

	sfe_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(q_job),
		.not_full(q_ready),
		.valid   (q_valid),
		.head_job(q_head),
		.pop     (q_pop)
	);

	sfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_job    (q_head),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

endmodule

>>> hw/rtl/sfe_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfe_front
// Accepts items, keeps the frame state and turns each item into a job.
// ---------------------------------------------------------------------------
module sfe_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [7:0]       cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  sfe_pkg::in_item_t in_item,
	input  logic             q_ready,
	output logic             q_push,
	output sfe_pkg::job_t    q_job
);
	import sfe_pkg::*;

	logic [7:0] start_marker_q;
	logic [5:0] min_frame_q;
	logic       frame_open_q;
	logic [6:0] bytes_left_q;
	logic [5:0] pad_count_q;

	logic       accept;
	logic       is_header;
	logic [5:0] min_eff;
	logic [7:0] need;
	logic [7:0] pad_wide;
	logic [5:0] pad_new;
	logic [6:0] left_dec;
	logic       pay_close;

	assign in_ready  = q_ready;
	assign accept    = in_valid && in_ready;
	assign is_header = (in_item.operation == OP_HEADER);

	assign min_eff  = (min_frame_q > MIN_FRAME_CAP) ? MIN_FRAME_CAP : min_frame_q;
	assign need     = {1'b0, in_item.length} + HEADER_LEN;
	assign pad_wide = ({2'b00, min_eff} > need) ? ({2'b00, min_eff} - need) : 8'd0;
	assign pad_new  = pad_wide[5:0];

	assign left_dec  = bytes_left_q - {6'd0, (bytes_left_q != 7'd0)};
	assign pay_close = (left_dec == 7'd0);

	// Payload items outside an open frame are taken and dropped.
	assign q_push = accept && (is_header || frame_open_q);

	always_comb begin
		if (is_header) begin
			q_job.bytes     = {in_item.checksum,
				in_item.sequence_req[3:0], in_item.kind,
				in_item.length, in_item.sequence_req[4],
				start_marker_q};
			q_job.last_idx  = LAST_IDX_HEADER;
			q_job.first_raw = 1'b1;
			q_job.close     = (in_item.length == 7'd0);
			q_job.pad       = pad_new;
		end else begin
			q_job.bytes     = {24'd0, in_item.data_byte};
			q_job.last_idx  = LAST_IDX_PAYLOAD;
			q_job.first_raw = 1'b0;
			q_job.close     = pay_close;
			q_job.pad       = pad_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			min_frame_q    <= MIN_FRAME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_MARKER: start_marker_q <= cfg_data;
				CFG_MIN_FRAME:    min_frame_q    <= cfg_data[5:0];
				default:          start_marker_q <= start_marker_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			bytes_left_q <= 7'd0;
			pad_count_q  <= 6'd0;
		end else if (accept) begin
			if (is_header) begin
				frame_open_q <= (in_item.length != 7'd0);
				bytes_left_q <= in_item.length;
				pad_count_q  <= (in_item.length == 7'd0) ? 6'd0 : pad_new;
			end else if (frame_open_q) begin
				if (pay_close) begin
					frame_open_q <= 1'b0;
					bytes_left_q <= 7'd0;
					pad_count_q  <= 6'd0;
				end else begin
					bytes_left_q <= left_dec;
				end
			end
		end
	end

endmodule

>>> hw/rtl/sfe_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfe_queue
// Small job queue between the front and the back end.
// ---------------------------------------------------------------------------
module sfe_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sfe_pkg::job_t push_job,
	output logic          not_full,
	output logic          valid,
	output sfe_pkg::job_t head_job,
	input  logic          pop
);
	import sfe_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          entry_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;

	assign not_full = (count_q != CW'(DEPTH));
	assign valid    = (count_q != '0);
	assign head_job = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/sfe_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfe_back
// Walks each job one wire byte per cycle while the output is not stalled:
// content bytes with stuffing, then padding, into a registered output.
// ---------------------------------------------------------------------------
module sfe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  sfe_pkg::job_t      q_job,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output sfe_pkg::out_item_t out_item
);
	import sfe_pkg::*;

	logic      busy_q;
	job_t      job_q;
	logic [1:0] idx_q;
	logic      ff_q;
	logic      pad_phase_q;
	logic [5:0] pad_q;
	logic      out_valid_q;
	out_item_t out_item_q;

	logic [7:0] cur;
	logic       special;
	logic       raw;
	logic       stuff_now;
	logic       bytes_done;
	logic       to_pad;
	logic       is_last;
	logic       end_now;
	logic [7:0] emit;
	logic       adv;
	logic       load;

	assign cur     = job_q.bytes[idx_q];
	assign special = (cur == STUFF_A) || (cur == STUFF_B);
	// The start marker goes out as it is.
	assign raw     = job_q.first_raw && (idx_q == 2'd0);

	assign stuff_now  = !pad_phase_q && !ff_q && special && !raw;
	assign bytes_done = !pad_phase_q && !stuff_now && (idx_q == job_q.last_idx);
	assign to_pad     = bytes_done && job_q.close && (job_q.pad != 6'd0);
	assign is_last    = pad_phase_q ? (pad_q == 6'd1) : (bytes_done && !to_pad);
	assign end_now    = pad_phase_q ? (pad_q == 6'd1)
		: (bytes_done && job_q.close && (job_q.pad == 6'd0));
	assign emit       = pad_phase_q ? 8'd0 : (ff_q ? STUFF_FILL : cur);

	assign adv   = busy_q && (!out_valid_q || out_ready);
	assign load  = q_valid && (!busy_q || (adv && is_last));
	assign q_pop = load;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= q_job;
		end
		if (adv) begin
			out_item_q.out_byte  <= emit;
			out_item_q.run_last  <= is_last;
			out_item_q.frame_end <= end_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= 2'd0;
			ff_q        <= 1'b0;
			pad_phase_q <= 1'b0;
			pad_q       <= 6'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (adv && is_last) begin
				busy_q <= 1'b0;
			end else if (adv) begin
				if (pad_phase_q) begin
					pad_q <= pad_q - 6'd1;
				end else if (stuff_now) begin
					ff_q <= 1'b1;
				end else if (to_pad) begin
					ff_q        <= 1'b0;
					pad_phase_q <= 1'b1;
					pad_q       <= job_q.pad;
				end else begin
					ff_q  <= 1'b0;
					idx_q <= idx_q + 2'd1;
				end
			end

			// A new job takes over in the cycle the previous one finishes.
			if (load) begin
				busy_q      <= 1'b1;
				idx_q       <= 2'd0;
				ff_q        <= 1'b0;
				pad_phase_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/sfe_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfe_checker
// Port-level checks on the encoder output, bound to the top level.
// ---------------------------------------------------------------------------
`include "stuffed_frame_encoder_defines.svh"

module sfe_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input sfe_pkg::out_item_t out_item
);
	import sfe_pkg::*;

	// A stalled result item stays put.
	`SFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "stalled output item changed")

	// The end of a frame is always the end of the item that caused it.
	`SFE_ASSERT_SAME(a_end_is_last, out_valid && out_item.frame_end, out_item.run_last, "frame_end without run_last")

	// Bytes of one item follow each other with no gap.
	`SFE_ASSERT_NEXT(a_no_gap, out_valid && out_ready && !out_item.run_last, out_valid, "gap inside an item's output")

endmodule

bind stuffed_frame_encoder sfe_checker u_sfe_checker (.*);
